// ----- rtl/cau_pkg.sv -----
`default_nettype none
package cau_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_SUB,
        KIND_MUL,
        KIND_DIV
    } kind_t;

endpackage
`default_nettype wire

// ----- rtl/cau_front.sv -----
`default_nettype none
module cau_front #(
    parameter int W = cau_pkg::WORD_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       in_op,
    input  wire logic [4*W-1:0]   in_operands,
    output logic                  push,
    input  wire logic             q_ready,
    output logic [4*W+1:0]        push_data
);

    logic             f_valid_reg, f_valid_next;
    logic [4*W+1:0]   f_data_reg;
    cau_pkg::kind_t   kind;

    always_comb begin
        case (in_op)
            cau_pkg::OP_ADD: kind = cau_pkg::KIND_ADD;
            cau_pkg::OP_SUB: kind = cau_pkg::KIND_SUB;
            cau_pkg::OP_MUL: kind = cau_pkg::KIND_MUL;
            cau_pkg::OP_DIV: kind = cau_pkg::KIND_DIV;
            default:         kind = cau_pkg::KIND_ADD;
        endcase
    end

    assign push      = f_valid_reg && q_ready;
    assign in_ready  = !f_valid_reg || q_ready;
    assign push_data = f_data_reg;

    always_comb begin
        f_valid_next = f_valid_reg;
        if (in_valid && in_ready) begin
            f_valid_next = 1'b1;
        end else if (push) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
        if (in_valid && in_ready) begin
            f_data_reg <= {kind, in_operands};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/cau_queue.sv -----
`default_nettype none
module cau_queue #(
    parameter int DW = 130
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire logic [DW-1:0] push_data,
    output logic               q_ready,
    input  wire logic          pop,
    output logic               q_valid,
    output logic [DW-1:0]      q_data
);

    logic [DW-1:0] mem_reg [0:1];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg, count_next;

    assign q_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push && pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/cau_back.sv -----
`default_nettype none
module cau_back #(
    parameter int W = cau_pkg::WORD_BITS_DEF,
    parameter int F = cau_pkg::FRAC_BITS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_valid,
    input  wire logic [4*W+1:0] q_data,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [W-1:0]        out_re,
    output logic [W-1:0]        out_im,
    output logic                out_ovf,
    output logic                out_dbz
);

    localparam int PW  = 2 * W;
    localparam int SW  = 2 * W + 1;
    localparam int QB  = W + 1;
    localparam int NW  = 2 * W + F;
    localparam int CW  = 3 * W + 1;
    localparam int MW  = 2 * W + 2;
    localparam logic [MW-1:0] HALF = (MW'(1) << F) >> 1;

    function automatic logic [W:0] sat(input logic neg, input logic [MW-1:0] mag);
        logic [MW-1:0] lim;
        logic [MW-1:0] m;
        logic          ov;
        lim = neg ? (MW'(1) << (W - 1)) : ((MW'(1) << (W - 1)) - MW'(1));
        ov  = mag > lim;
        m   = ov ? lim : mag;
        sat = {ov, neg ? (-m[W-1:0]) : m[W-1:0]};
    endfunction

    logic en;
    assign en  = !out_valid || out_ready;
    assign pop = en && q_valid;

    cau_pkg::kind_t kind_in;
    logic signed [W-1:0] ar, ai, br, bi;
    assign kind_in = cau_pkg::kind_t'(q_data[4*W+1:4*W]);
    assign ar = q_data[W-1:0];
    assign ai = q_data[2*W-1:W];
    assign br = q_data[3*W-1:2*W];
    assign bi = q_data[4*W-1:3*W];

    // products and add/sub
    logic                v1_reg;
    cau_pkg::kind_t      k1_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, sq_r_reg, sq_i_reg;
    logic signed [W:0]   as_re_reg, as_im_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= q_valid;
        end
        if (en) begin
            k1_reg   <= kind_in;
            p_rr_reg <= ar * br;
            p_ii_reg <= ai * bi;
            p_ri_reg <= ar * bi;
            p_ir_reg <= ai * br;
            sq_r_reg <= br * br;
            sq_i_reg <= bi * bi;
            if (kind_in == cau_pkg::KIND_SUB) begin
                as_re_reg <= (W+1)'(ar) - (W+1)'(br);
                as_im_reg <= (W+1)'(ai) - (W+1)'(bi);
            end else begin
                as_re_reg <= (W+1)'(ar) + (W+1)'(br);
                as_im_reg <= (W+1)'(ai) + (W+1)'(bi);
            end
        end
    end

    // cross sums and divisor
    logic                v2_reg;
    cau_pkg::kind_t      k2_reg;
    logic signed [SW-1:0] num_re_reg, num_im_reg;
    logic [PW-1:0]       den_reg;
    logic signed [W:0]   as2_re_reg, as2_im_reg;
    logic signed [SW-1:0] e_rr, e_ii, e_ri, e_ir;

    assign e_rr = SW'(p_rr_reg);
    assign e_ii = SW'(p_ii_reg);
    assign e_ri = SW'(p_ri_reg);
    assign e_ir = SW'(p_ir_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            k2_reg     <= k1_reg;
            as2_re_reg <= as_re_reg;
            as2_im_reg <= as_im_reg;
            den_reg    <= sq_r_reg + sq_i_reg;
            if (k1_reg == cau_pkg::KIND_DIV) begin
                num_re_reg <= e_rr + e_ii;
                num_im_reg <= e_ir - e_ri;
            end else begin
                num_re_reg <= e_rr - e_ii;
                num_im_reg <= e_ri + e_ir;
            end
        end
    end

    // divider chain, index 0 is the set-up stage
    logic                v_reg    [0:QB];
    cau_pkg::kind_t      k_reg    [0:QB];
    logic [W-1:0]        res_re_reg [0:QB];
    logic [W-1:0]        res_im_reg [0:QB];
    logic                ov_reg   [0:QB];
    logic                dbz_reg  [0:QB];
    logic                neg_re_reg [0:QB];
    logic                neg_im_reg [0:QB];
    logic                pov_re_reg [0:QB];
    logic                pov_im_reg [0:QB];
    logic [NW-1:0]       r_re_reg [0:QB];
    logic [NW-1:0]       r_im_reg [0:QB];
    logic [QB-1:0]       q_re_reg [0:QB];
    logic [QB-1:0]       q_im_reg [0:QB];
    logic [PW-1:0]       d_reg    [0:QB];

    logic          n_re_neg, n_im_neg, a_re_neg, a_im_neg;
    logic [SW-1:0] n_re_mag, n_im_mag;
    logic [W:0]    a_re_mag, a_im_mag;
    logic [NW-1:0] n_re_sh, n_im_sh;
    logic [W:0]    s_as_re, s_as_im, s_mul_re, s_mul_im;

    assign n_re_neg = num_re_reg[SW-1];
    assign n_im_neg = num_im_reg[SW-1];
    assign n_re_mag = n_re_neg ? -num_re_reg : num_re_reg;
    assign n_im_mag = n_im_neg ? -num_im_reg : num_im_reg;
    assign a_re_neg = as2_re_reg[W];
    assign a_im_neg = as2_im_reg[W];
    assign a_re_mag = a_re_neg ? -as2_re_reg : as2_re_reg;
    assign a_im_mag = a_im_neg ? -as2_im_reg : as2_im_reg;
    assign n_re_sh  = NW'(n_re_mag[PW-1:0]) << F;
    assign n_im_sh  = NW'(n_im_mag[PW-1:0]) << F;
    assign s_as_re  = sat(a_re_neg, MW'(a_re_mag));
    assign s_as_im  = sat(a_im_neg, MW'(a_im_mag));
    assign s_mul_re = sat(n_re_neg, (MW'(n_re_mag) + HALF) >> F);
    assign s_mul_im = sat(n_im_neg, (MW'(n_im_mag) + HALF) >> F);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= v2_reg;
        end
        if (en) begin
            k_reg[0]      <= k2_reg;
            dbz_reg[0]    <= (k2_reg == cau_pkg::KIND_DIV) && (den_reg == '0);
            neg_re_reg[0] <= n_re_neg;
            neg_im_reg[0] <= n_im_neg;
            r_re_reg[0]   <= n_re_sh;
            r_im_reg[0]   <= n_im_sh;
            d_reg[0]      <= den_reg;
            q_re_reg[0]   <= '0;
            q_im_reg[0]   <= '0;
            pov_re_reg[0] <= CW'(n_re_sh) >= (CW'(den_reg) << QB);
            pov_im_reg[0] <= CW'(n_im_sh) >= (CW'(den_reg) << QB);
            if (k2_reg == cau_pkg::KIND_MUL) begin
                res_re_reg[0] <= s_mul_re[W-1:0];
                res_im_reg[0] <= s_mul_im[W-1:0];
                ov_reg[0]     <= s_mul_re[W] | s_mul_im[W];
            end else begin
                res_re_reg[0] <= s_as_re[W-1:0];
                res_im_reg[0] <= s_as_im[W-1:0];
                ov_reg[0]     <= s_as_re[W] | s_as_im[W];
            end
        end
    end

    for (genvar k = 1; k <= QB; k++) begin : g_div
        localparam int SH = QB - k;
        logic [CW-1:0] dsh, rz_re, rz_im;
        logic          ge_re, ge_im;
        assign dsh   = CW'(d_reg[k-1]) << SH;
        assign rz_re = CW'(r_re_reg[k-1]);
        assign rz_im = CW'(r_im_reg[k-1]);
        assign ge_re = rz_re >= dsh;
        assign ge_im = rz_im >= dsh;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_reg[k-1];
            end
            if (en) begin
                k_reg[k]      <= k_reg[k-1];
                res_re_reg[k] <= res_re_reg[k-1];
                res_im_reg[k] <= res_im_reg[k-1];
                ov_reg[k]     <= ov_reg[k-1];
                dbz_reg[k]    <= dbz_reg[k-1];
                neg_re_reg[k] <= neg_re_reg[k-1];
                neg_im_reg[k] <= neg_im_reg[k-1];
                pov_re_reg[k] <= pov_re_reg[k-1];
                pov_im_reg[k] <= pov_im_reg[k-1];
                d_reg[k]      <= d_reg[k-1];
                r_re_reg[k]   <= ge_re ? NW'(rz_re - dsh) : r_re_reg[k-1];
                r_im_reg[k]   <= ge_im ? NW'(rz_im - dsh) : r_im_reg[k-1];
                q_re_reg[k]   <= q_re_reg[k-1] | (QB'(ge_re) << SH);
                q_im_reg[k]   <= q_im_reg[k-1] | (QB'(ge_im) << SH);
            end
        end
    end

    // rounding half away from zero, then saturation
    logic          rnd_re, rnd_im;
    logic [MW-1:0] qm_re, qm_im;
    logic [W:0]    s_div_re, s_div_im;

    assign rnd_re   = (CW'(r_re_reg[QB]) << 1) >= CW'(d_reg[QB]);
    assign rnd_im   = (CW'(r_im_reg[QB]) << 1) >= CW'(d_reg[QB]);
    assign qm_re    = pov_re_reg[QB] ? '1 : MW'(q_re_reg[QB]) + MW'(rnd_re);
    assign qm_im    = pov_im_reg[QB] ? '1 : MW'(q_im_reg[QB]) + MW'(rnd_im);
    assign s_div_re = sat(neg_re_reg[QB], qm_re);
    assign s_div_im = sat(neg_im_reg[QB], qm_im);

    logic         out_valid_reg;
    logic [W-1:0] out_re_reg, out_im_reg;
    logic         out_ovf_reg, out_dbz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v_reg[QB];
        end
        if (en) begin
            if (k_reg[QB] != cau_pkg::KIND_DIV) begin
                out_re_reg  <= res_re_reg[QB];
                out_im_reg  <= res_im_reg[QB];
                out_ovf_reg <= ov_reg[QB];
                out_dbz_reg <= 1'b0;
            end else if (dbz_reg[QB]) begin
                out_re_reg  <= '0;
                out_im_reg  <= '0;
                out_ovf_reg <= 1'b0;
                out_dbz_reg <= 1'b1;
            end else begin
                out_re_reg  <= s_div_re[W-1:0];
                out_im_reg  <= s_div_im[W-1:0];
                out_ovf_reg <= s_div_re[W] | s_div_im[W];
                out_dbz_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;
    assign out_ovf   = out_ovf_reg;
    assign out_dbz   = out_dbz_reg;

endmodule
`default_nettype wire

// ----- rtl/complex_arith_unit.sv -----
// Complex-number ALU on signed fixed-point operands (Q16.16 by default).
// Input stream: one transfer per item; s_axis_tuser carries the operation
// (add, subtract, multiply, divide), s_axis_tdata the operands a and b.
// Output stream: one transfer per item, in input order; m_axis_tdata holds
// the saturated result, m_axis_tuser the overflow and divide-by-zero flags.
// Throughput: one item per cycle in steady state, for every operation,
// while m_axis_tready is high. Every item, whatever its operation, passes
// the same stages, including the restoring divider with one quotient bit
// per pipeline stage.
// Front register and a two-entry queue sit ahead of the arithmetic pipeline.
// When m_axis_tready is low with a result waiting, the pipeline freezes;
// the queue and front register then fill and s_axis_tready drops.
// A zero divisor gives a zero result with the divide-by-zero flag set.
// Reset (aresetn low, synchronous) empties every stage; no result is
// pending afterwards and the block takes an item in the next cycle.
`default_nettype none
module complex_arith_unit #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // a_real, a_imag, b_real, b_imag
    input  wire logic [((4*WORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // operation
    input  wire logic [1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // result_real, result_imag
    output logic [((2*WORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // overflow, divide_by_zero
    output logic [1:0]            m_axis_tuser
);

    localparam int W   = WORD_BITS;
    localparam int ODW = ((2*W+7)/8)*8;
    localparam int QDW = 4*W + 2;

    logic           push, q_ready, q_valid, pop;
    logic [QDW-1:0] push_data, q_data;
    logic [W-1:0]   res_re, res_im;
    logic           ovf, dbz;

    cau_front #(.W(W)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_op       (s_axis_tuser),
        .in_operands (s_axis_tdata[4*W-1:0]),
        .push        (push),
        .q_ready     (q_ready),
        .push_data   (push_data)
    );

    cau_queue #(.DW(QDW)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .q_ready   (q_ready),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    cau_back #(.W(W), .F(FRAC_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_re    (res_re),
        .out_im    (res_im),
        .out_ovf   (ovf),
        .out_dbz   (dbz)
    );

    assign m_axis_tdata = ODW'({res_im, res_re});
    assign m_axis_tuser = {dbz, ovf};

endmodule
`default_nettype wire
